[hdl/upd_pkg.sv]
// shared types, constants and helper functions of the url percent decoder
package upd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CAP_W       = 16;
  localparam int CMP_W       = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // register map
  localparam logic [2:0] ADDR_OUT_CAPACITY = 3'd0;

  // escape tracking
  typedef enum logic [2:0] {
    PH_NONE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } ph_t;

  // one classified request: up to three candidate bytes and the end flag
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] bytes;
    logic            eos;
  } upd_cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    hex_value = v[3:0];
  endfunction

endpackage

[hdl/upd_front.sv]
// front end: escape tracking and classification of each input byte into candidate bytes
module upd_front import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_eos,
  input  logic       q_full,
  output logic       in_ready,
  output logic       push,
  output upd_cmd_t   cmd
);

  ph_t        phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    logic [1:0] cnt;
    logic       plain_go;
    cnt       = 2'd0;
    plain_go  = 1'b0;
    cmd       = '0;
    held_nxt  = held_r;
    phase_nxt = PH_NONE;
    unique case (phase_r)
      PH_PCT: begin
        if (is_hex(in_byte)) begin
          held_nxt  = in_byte;
          phase_nxt = PH_DIGIT;
        end else begin
          cmd.bytes[0] = CH_PERCENT;
          cnt          = 2'd1;
          plain_go     = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (is_hex(in_byte)) begin
          cmd.bytes[0] = {hex_value(held_r), hex_value(in_byte)};
          cnt          = 2'd1;
        end else begin
          cmd.bytes[0] = CH_PERCENT;
          cmd.bytes[1] = held_r;
          cnt          = 2'd2;
          plain_go     = 1'b1;
        end
      end
      default: begin
        plain_go = 1'b1;
      end
    endcase
    if (plain_go) begin
      if (in_byte == CH_PERCENT) begin
        phase_nxt = PH_PCT;
      end else begin
        cmd.bytes[cnt] = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
        cnt            = 2'(cnt + 2'd1);
      end
    end
    // flush a pending escape at end of string
    if (in_eos) begin
      if (phase_nxt == PH_PCT) begin
        cmd.bytes[cnt] = CH_PERCENT;
        cnt            = 2'(cnt + 2'd1);
      end else if (phase_nxt == PH_DIGIT) begin
        cmd.bytes[cnt]                = CH_PERCENT;
        cmd.bytes[2'(cnt + 2'd1)]     = held_nxt;
        cnt                           = 2'(cnt + 2'd2);
      end
      phase_nxt = PH_NONE;
      held_nxt  = 8'h00;
    end
    cmd.n   = cnt;
    cmd.eos = in_eos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NONE;
      held_r  <= 8'h00;
    end else if (push) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  a_held_is_hex: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DIGIT |-> is_hex(held_r))
    else $error("held digit is not a hex character");

endmodule

[hdl/upd_queue.sv]
// small request queue between front and back end
module upd_queue import upd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  upd_cmd_t wr_data,
  output logic     full,
  input  logic     rd_en,
  output upd_cmd_t rd_data,
  output logic     empty
);

  upd_cmd_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr_r <= QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (rd_en && !empty) begin
        rd_ptr_r <= QPTR_W'(rd_ptr_r + 1'b1);
      end
      unique case ({wr_en && !full, rd_en && !empty})
        2'b10:   count_r <= QCNT_W'(count_r + 1'b1);
        2'b01:   count_r <= QCNT_W'(count_r - 1'b1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("pop from empty queue");

endmodule

[hdl/upd_back.sv]
// back end: capacity accounting, truncation flag and serialization onto the output register
module upd_back import upd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  upd_cmd_t         head,
  input  logic             head_valid,
  input  logic [CAP_W-1:0] cap,
  output logic             pop,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_has,
  output logic             out_last,
  output logic             out_trunc
);

  localparam logic [CMP_W-1:0] LIMIT_EXT =
    {{(CMP_W-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

  logic [COUNT_WIDTH-1:0] wc_r, wc_nxt;
  logic                   drop_r, drop_nxt;
  logic [1:0]             k_r, k_nxt;
  logic                   valid_r;
  logic [7:0]             byte_r;
  logic                   has_r, last_r, trunc_r;

  logic             adv, fit, next_fit, more, fin, drop_new;
  logic             load, ld_has, ld_last, ld_trunc;
  logic [7:0]       ld_byte;
  logic [CMP_W-1:0] wc_ext, cap_ext;

  assign wc_ext   = CMP_W'(wc_r);
  assign cap_ext  = CMP_W'(cap);
  assign fit      = (CMP_W'(wc_ext + 1'b1) < cap_ext) && (wc_ext < LIMIT_EXT);
  assign next_fit = (CMP_W'(wc_ext + 2'd2) < cap_ext) &&
                    (CMP_W'(wc_ext + 1'b1) < LIMIT_EXT);
  assign more     = (2'(k_r + 2'd1) < head.n);
  assign fin      = !more || !next_fit;
  assign adv      = head_valid && (!valid_r || out_ready);

  always_comb begin
    wc_nxt   = wc_r;
    drop_nxt = drop_r;
    k_nxt    = k_r;
    pop      = 1'b0;
    load     = 1'b0;
    ld_byte  = 8'h00;
    ld_has   = 1'b0;
    ld_last  = 1'b0;
    ld_trunc = 1'b0;
    drop_new = drop_r;
    if (adv) begin
      if (head.n == 2'd0 || !fit) begin
        // everything of this request is dropped
        drop_new = drop_r | (head.n != 2'd0);
        pop      = 1'b1;
        k_nxt    = 2'd0;
        if (head.eos) begin
          load     = 1'b1;
          ld_last  = 1'b1;
          ld_trunc = drop_new;
          wc_nxt   = '0;
          drop_nxt = 1'b0;
        end else begin
          drop_nxt = drop_new;
        end
      end else begin
        load     = 1'b1;
        ld_byte  = head.bytes[k_r];
        ld_has   = 1'b1;
        ld_trunc = drop_r;
        wc_nxt   = COUNT_WIDTH'(wc_r + 1'b1);
        if (fin) begin
          // later candidates, if any, no longer fit
          drop_new = drop_r | more;
          pop      = 1'b1;
          k_nxt    = 2'd0;
          if (head.eos) begin
            ld_last  = 1'b1;
            ld_trunc = drop_new;
            wc_nxt   = '0;
            drop_nxt = 1'b0;
          end else begin
            drop_nxt = drop_new;
          end
        end else begin
          k_nxt = 2'(k_r + 2'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r    <= '0;
      drop_r  <= 1'b0;
      k_r     <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      wc_r   <= wc_nxt;
      drop_r <= drop_nxt;
      k_r    <= k_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= ld_byte;
      has_r   <= ld_has;
      last_r  <= ld_last;
      trunc_r <= ld_trunc;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_has   = has_r;
  assign out_last  = last_r;
  assign out_trunc = trunc_r;

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !has_r |-> last_r && byte_r == 8'h00)
    else $error("end marker without last or with a byte");

  a_sub_index: assert property (@(posedge clk) disable iff (!rst_n)
    k_r != 2'd0 |-> head_valid && k_r < head.n)
    else $error("candidate index outside current request");

endmodule

[hdl/url_percent_decoder.sv]
// top level of the streaming url percent decoder with its configuration register
//
// usage
//   input stream: in_tdata[7:0] is the next raw byte of an encoded string, in_tlast
//   marks the last byte of the string. output stream: out_tdata[7:0] is a decoded
//   byte, out_tdata[8] the truncated flag, out_tuser says the byte is present (0 on
//   a bare end marker), out_tlast marks the final result of a string.
//   "%hh" (either case) becomes one byte, "+" a space, a broken escape is passed
//   through literally. at most out_capacity minus one bytes per string are sent,
//   the rest is dropped and flagged.
//   configuration: out_capacity at byte address 0 over the apb port, written
//   while the stream is idle. pready is always high.
// flow
//   an accepted request is written into the queue, and the output register loads
//   its results from the queue head once the back end takes it. a byte that yields
//   more than one result holds the queue head until each of its results is loaded
//   (up to three when an escape fails after its first digit), and the four-entry
//   queue absorbs such bursts before in_tready drops.
// reset: escape state, counters and queue clear, out_capacity returns to 256.
// stall: with out_tready low the output register holds; the queue fills and then
//   in_tready falls, so no request is lost.
module url_percent_decoder import upd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata fields from bit 0: in_byte[7:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  // out_tdata fields from bit 0: out_byte[7:0], truncated[8], zero fill [15:9]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  // out_tuser fields from bit 0: has_byte[0]
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [CAP_W-1:0] cap_r;

  // front to queue
  logic     q_full, q_empty, push, pop;
  upd_cmd_t push_cmd, head;

  // back end result fields
  logic [7:0] res_byte;
  logic       res_trunc;

  // apb register, word aligned
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == ADDR_OUT_CAPACITY[2]) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = 32'h0;
    if (cfg_paddr[2] == ADDR_OUT_CAPACITY[2]) begin
      cfg_prdata = 32'(cap_r);
    end
  end

  // classify each byte against the escape state
  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_eos   (in_tlast),
    .q_full   (q_full),
    .in_ready (in_tready),
    .push     (push),
    .cmd      (push_cmd)
  );

  // decouples the front from output stalls
  upd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_cmd),
    .full    (q_full),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (q_empty)
  );

  // capacity check and one result per cycle while the output is not stalled
  upd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!q_empty),
    .cap        (cap_r),
    .pop        (pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_byte   (res_byte),
    .out_has    (out_tuser),
    .out_last   (out_tlast),
    .out_trunc  (res_trunc)
  );

  assign out_tdata = {7'b0, res_trunc, res_byte};

endmodule
